// ----- rtl/osrb_pkg.sv -----
`default_nettype none
package osrb_pkg;
  localparam int DEPTH = 4096;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = AW + 1;
  localparam int SW = 24;
  localparam int SUMW = SW + CW;

  typedef enum logic [2:0] {
    CMD_PUSH = 3'd0, CMD_DROP = 3'd1, CMD_READ = 3'd2,
    CMD_CHREAD = 3'd3, CMD_STATS = 3'd4, CMD_CLEAR = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CHDIV, ST_RDWAIT, ST_SCAN, ST_MEAN, ST_DIV, ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic div_start;
    logic scan_start;
    logic scan_step;
    logic mean_start;
    logic rd_issue;
    logic finish;
    logic out_load;
  } ctl_t;

  typedef struct packed {
    logic div_done;
    logic scan_last;
    logic out_full;
    logic [2:0] cmd;
  } sts_t;
endpackage
`default_nettype wire

// ----- rtl/osrb_if.sv -----
`default_nettype none
interface osrb_in_if;
  logic valid;
  logic ready;
  logic [2:0] cmd;
  logic signed [23:0] sample_in;
  logic [12:0] drop_count;
  logic [11:0] position;
  logic [7:0] channel;
  modport source (output valid, cmd, sample_in, drop_count, position, channel, input ready);
  modport sink (input valid, cmd, sample_in, drop_count, position, channel, output ready);
endinterface

interface osrb_out_if;
  logic valid;
  logic ready;
  logic signed [23:0] read_value;
  logic [22:0] max_value;
  logic signed [23:0] min_value;
  logic signed [23:0] mean_value;
  logic [12:0] fill_count;
  logic invalid;
  modport source (output valid, read_value, max_value, min_value, mean_value, fill_count,
                  invalid, input ready);
  modport sink (input valid, read_value, max_value, min_value, mean_value, fill_count,
                invalid, output ready);
endinterface
`default_nettype wire

// ----- rtl/osrb_ram.sv -----
`default_nettype none
module osrb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- rtl/osrb_div.sv -----
`default_nettype none
// restoring divider, one quotient bit per cycle, unsigned
module osrb_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [osrb_pkg::SUMW-1:0]   dividend,
  input  wire logic [osrb_pkg::CW-1:0]     divisor,
  output logic                             done,
  output logic      [osrb_pkg::SUMW-1:0]   quotient
);
  import osrb_pkg::*;
  localparam int NW = $clog2(SUMW + 1);
  logic [SUMW-1:0] q_r, q_nxt;
  logic [CW:0] rem_r, rem_nxt;
  logic [CW-1:0] d_r, d_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic busy_r, busy_nxt;
  logic [CW:0] trial;

  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; d_nxt = d_r; n_nxt = n_r; busy_nxt = busy_r;
    trial = {rem_r[CW-1:0], q_r[SUMW-1]};
    if (start) begin
      q_nxt = dividend; rem_nxt = '0; d_nxt = divisor;
      n_nxt = NW'(SUMW); busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, d_r}) begin
        rem_nxt = trial - {1'b0, d_r};
        q_nxt = {q_r[SUMW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[SUMW-2:0], 1'b0};
      end
      n_nxt = n_r - 1'b1;
      if (n_r == NW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      n_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      n_r <= n_nxt;
    end
    q_r <= q_nxt; rem_r <= rem_nxt; d_r <= d_nxt;
  end

  assign done = busy_r && (n_r == NW'(1));
  assign quotient = q_nxt;
endmodule
`default_nettype wire

// ----- rtl/osrb_ctrl.sv -----
`default_nettype none
module osrb_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire osrb_pkg::sts_t  sts,
  output osrb_pkg::ctl_t       ctl
);
  import osrb_pkg::*;
  state_t st_r, st_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ST_IDLE;
    else st_r <= st_nxt;
  end

  always_comb begin
    st_nxt = st_r;
    ctl = '0;
    in_ready = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        in_ready = !sts.out_full;
        if (in_valid && !sts.out_full) begin
          ctl.load = 1'b1;
          if (sts.cmd == CMD_CHREAD) begin
            ctl.div_start = 1'b1;
            st_nxt = ST_CHDIV;
          end else if (sts.cmd == CMD_READ) begin
            ctl.rd_issue = 1'b1;
            st_nxt = ST_RDWAIT;
          end else if (sts.cmd == CMD_STATS) begin
            ctl.scan_start = 1'b1;
            st_nxt = ST_SCAN;
          end else begin
            ctl.exec = 1'b1;
            ctl.out_load = 1'b1;
          end
        end
      end
      ST_CHDIV: if (sts.div_done) begin
        ctl.rd_issue = 1'b1;
        st_nxt = ST_RDWAIT;
      end
      ST_RDWAIT: st_nxt = ST_OUT;
      ST_SCAN: begin
        ctl.scan_step = 1'b1;
        if (sts.scan_last) st_nxt = ST_MEAN;
      end
      // sum holds the last sample from here on
      ST_MEAN: begin
        ctl.mean_start = 1'b1;
        st_nxt = ST_DIV;
      end
      ST_DIV: if (sts.div_done) st_nxt = ST_OUT;
      ST_OUT: if (!sts.out_full) begin
        ctl.finish = 1'b1;
        ctl.out_load = 1'b1;
        st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ----- rtl/osrb_dp.sv -----
`default_nettype none
module osrb_dp (
  input  wire logic           clk,
  input  wire logic           rst_n,
  osrb_in_if.sink             in_ch,
  osrb_out_if.source          out_ch,
  input  wire logic           cfg_we,
  input  wire logic [8:0]     cfg_wdata,
  input  wire osrb_pkg::ctl_t ctl,
  output osrb_pkg::sts_t      sts
);
  import osrb_pkg::*;

  logic [AW-1:0] head_r, tail_r;
  logic [CW-1:0] cnt_r;
  logic [8:0] chc_r;
  logic [2:0] cmd_r;
  logic [11:0] pos_r;
  logic [7:0] chan_r;
  logic bad_r;
  logic [CW-1:0] idx_r;
  logic rvalid_r;
  logic signed [SW-1:0] mx_r, mn_r;
  logic signed [SUMW-1:0] sum_r;
  logic [AW-1:0] rdaddr_r;
  logic [AW+8:0] mul_r;
  logic ovalid_r;
  logic signed [23:0] o_rd_r, o_mn_r, o_mean_r;
  logic [22:0] o_mx_r;
  logic [12:0] o_fill_r;
  logic o_bad_r;

  logic [SW-1:0] rdata;
  logic we;
  logic [AW-1:0] raddr;
  logic div_start, div_done;
  logic [SUMW-1:0] div_a, div_q;
  logic [CW-1:0] div_b;
  logic neg;
  logic signed [SW-1:0] s;

  assign s = rdata;
  assign we = ctl.exec && in_ch.cmd == CMD_PUSH;

  // channel read: stored/channel_count via the shared divider, mean likewise
  assign div_start = ctl.div_start || ctl.mean_start;
  always_comb begin
    neg = sum_r[SUMW-1];
    if (ctl.div_start) begin
      div_a = SUMW'(cnt_r);
      div_b = CW'(chc_r);
    end else begin
      div_a = neg ? SUMW'(-sum_r) : SUMW'(sum_r);
      div_b = cnt_r;
    end
  end

  osrb_div u_div (.clk, .rst_n, .start(div_start), .dividend(div_a), .divisor(div_b),
    .done(div_done), .quotient(div_q));

  always_comb begin
    raddr = rdaddr_r;
    if (ctl.rd_issue) begin
      // plain read issues at the transfer, channel read after the divide
      if (ctl.load) raddr = head_r + AW'(in_ch.position);
      else raddr = head_r + AW'(chan_r) + AW'(mul_r);
    end else if (ctl.scan_start) begin
      raddr = head_r;
    end else if (ctl.scan_step) begin
      raddr = rdaddr_r + 1'b1;
    end
  end

  osrb_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_ram (.clk, .we, .waddr(tail_r),
    .wdata(in_ch.sample_in), .raddr, .rdata);

  assign sts.div_done = div_done;
  // empty store ends the scan at once
  assign sts.scan_last = !rvalid_r || (idx_r + 1'b1 >= cnt_r);
  assign sts.out_full = ovalid_r && !out_ch.ready;
  assign sts.cmd = in_ch.cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0; tail_r <= '0; cnt_r <= '0; chc_r <= 9'd1; ovalid_r <= 1'b0;
      rvalid_r <= 1'b0;
    end else begin
      if (cfg_we) chc_r <= cfg_wdata;
      if (ovalid_r && out_ch.ready) ovalid_r <= 1'b0;
      if (ctl.out_load) ovalid_r <= 1'b1;
      if (ctl.exec) begin
        unique case (in_ch.cmd)
          CMD_PUSH: begin
            tail_r <= tail_r + 1'b1;
            if (cnt_r >= CW'(DEPTH)) head_r <= head_r + 1'b1;
            else cnt_r <= cnt_r + 1'b1;
          end
          CMD_DROP: begin
            if (CW'(in_ch.drop_count) > cnt_r) begin
              cnt_r <= '0; head_r <= '0; tail_r <= '0;
            end else begin
              head_r <= head_r + AW'(in_ch.drop_count);
              cnt_r <= cnt_r - CW'(in_ch.drop_count);
            end
          end
          CMD_CLEAR: begin
            cnt_r <= '0; head_r <= '0; tail_r <= '0;
          end
          default: ;
        endcase
      end
      if (ctl.scan_start) rvalid_r <= cnt_r != '0;
      else if (ctl.scan_step && sts.scan_last) rvalid_r <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r <= in_ch.cmd;
      pos_r <= in_ch.position; chan_r <= in_ch.channel;
      bad_r <= (in_ch.cmd == CMD_READ) && (CW'(in_ch.position) >= cnt_r);
      mul_r <= (AW+9)'(in_ch.position) * (AW+9)'(chc_r);
    end
    if (div_done && cmd_r == CMD_CHREAD)
      bad_r <= chc_r == '0 || {1'b0, chan_r} >= chc_r ||
               SUMW'(pos_r) + 1'b1 > div_q;
    rdaddr_r <= raddr;
    if (ctl.scan_start) begin
      idx_r <= '0; mx_r <= '0; mn_r <= '0; sum_r <= '0;
    end else if (ctl.scan_step && rvalid_r) begin
      idx_r <= idx_r + 1'b1;
      if (s > mx_r) mx_r <= s;
      if (s < mn_r) mn_r <= s;
      sum_r <= sum_r + SUMW'(s);
    end
    if (ctl.out_load) begin
      o_fill_r <= 13'(cnt_r); o_bad_r <= 1'b0;
      o_rd_r <= '0; o_mx_r <= '0; o_mn_r <= '0; o_mean_r <= '0;
      if (ctl.exec) begin
        unique case (in_ch.cmd)
          CMD_PUSH: o_fill_r <= (cnt_r >= CW'(DEPTH)) ? 13'(cnt_r) : 13'(cnt_r + 1'b1);
          CMD_DROP: o_fill_r <= (CW'(in_ch.drop_count) > cnt_r) ? '0
                                : 13'(cnt_r - CW'(in_ch.drop_count));
          CMD_CLEAR: o_fill_r <= '0;
          default: ;
        endcase
      end else if (cmd_r == CMD_STATS) begin
        o_mx_r <= mx_r[22:0]; o_mn_r <= mn_r;
        // empty store reports a zero mean
        if (cnt_r != '0) o_mean_r <= neg ? -24'(div_q) : 24'(div_q);
      end else begin
        o_bad_r <= bad_r;
        o_rd_r <= bad_r ? '0 : s;
      end
    end
  end

  assign out_ch.valid = ovalid_r;
  assign out_ch.read_value = o_rd_r;
  assign out_ch.max_value = o_mx_r;
  assign out_ch.min_value = o_mn_r;
  assign out_ch.mean_value = o_mean_r;
  assign out_ch.fill_count = o_fill_r;
  assign out_ch.invalid = o_bad_r;
endmodule
`default_nettype wire

// ----- rtl/overwriting_sample_ring_buffer_core.sv -----
`default_nettype none
// ring store of 4096 signed 24-bit samples; push overwrites the oldest when full.
// one command per transfer, one result transfer per command. push, drop, clear finish
// at the transfer; read does one ram read; channel read runs fill / channel_count on
// the bit-serial divider, then one ram read; stats scans the store on the single ram
// read port, one sample a cycle, then runs the mean divider. no clearing pass.
module overwriting_sample_ring_buffer_core (
  input  wire logic clk,
  input  wire logic rst_n,
  osrb_in_if.sink   in_ch,
  osrb_out_if.source out_ch,
  input  wire logic cfg_we,
  input  wire logic [8:0] cfg_wdata
);
  import osrb_pkg::*;
  ctl_t ctl;
  sts_t sts;
  logic rdy;

  osrb_ctrl u_ctrl (.clk, .rst_n, .in_valid(in_ch.valid), .in_ready(rdy), .sts, .ctl);
  osrb_dp u_dp (.clk, .rst_n, .in_ch, .out_ch, .cfg_we, .cfg_wdata, .ctl, .sts);

  // input transfers only in idle with room in the result register
  assign in_ch.ready = rdy;
endmodule
`default_nettype wire
